// ===== hdl/rtc_pkg.sv =====
// Shared types, constants and calendar helpers for the real-time clock block.
package rtc_pkg;

    localparam int TICK_W = 16;
    localparam int ZONE_W = 5;
    localparam int CFG_W  = 16;
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;

    localparam logic [TICK_W-1:0] TPS_RESET  = 16'd1000;
    localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd1;
    localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2026;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;

    localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
    localparam logic [MON_W-1:0]  MON_LAST   = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_LAST   = 5'd31;

    // Hour sum is at most 31 + 31, so two conditional subtractions cover mod 24.
    localparam logic [HOUR_W:0] HOURS_PER_DAY = 6'd24;
    localparam logic [HOUR_W:0] HOURS_TWO_DAY = 6'd48;

    // Residues of the reset year used for the leap-year rule.
    localparam logic [1:0] YR_MOD4_RESET   = 2'd2;
    localparam logic [6:0] YR_MOD100_RESET = 7'd26;
    localparam logic [8:0] YR_MOD400_RESET = 9'd26;
    localparam logic [6:0] YR_MOD100_LAST  = 7'd99;
    localparam logic [8:0] YR_MOD400_LAST  = 9'd399;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SYNC = 1'b1;

    localparam logic CFG_TPS  = 1'b0;
    localparam logic CFG_ZONE = 1'b1;

    typedef struct packed {
        logic en;
        logic load;
    } cell_ctl_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        begin
            case (m)
                4'd2:                       d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
                default:                    d = 5'd31;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== hdl/rtc_calendar_counter.sv =====
// Top level of the real-time clock with Gregorian calendar.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  in       | in_valid/in_stall  | req_type, sync_hour, sync_minute, sync_second
//  out      | out_valid/out_stall| second_tick, at_midnight, year .. second
//  cfg      | cfg_we             | cfg_index, cfg_data
//
// One item per cycle unless the input stalls; each item's result is registered and shown in the cycle after acceptance.
// The carry ripples combinationally through the cell row (ticks, second .. year).
// Reset sets the clock to 2026-01-01 00:00:00 and the registers to their defaults.
// The input stalls only while a result is held and the output is stalled.
module rtc_calendar_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [rtc_pkg::HOUR_W-1:0]    sync_hour,
    input  logic [rtc_pkg::MIN_W-1:0]     sync_minute,
    input  logic [rtc_pkg::SEC_W-1:0]     sync_second,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          second_tick,
    output logic                          at_midnight,
    output logic [rtc_pkg::YEAR_W-1:0]    year,
    output logic [rtc_pkg::MON_W-1:0]     month,
    output logic [rtc_pkg::DAY_W-1:0]     day,
    output logic [rtc_pkg::HOUR_W-1:0]    hour,
    output logic [rtc_pkg::MIN_W-1:0]     minute,
    output logic [rtc_pkg::SEC_W-1:0]     second,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [rtc_pkg::CFG_W-1:0]     cfg_data
);

    logic [rtc_pkg::TICK_W-1:0] tps_reg;
    logic [rtc_pkg::ZONE_W-1:0] zone_reg;

    logic                       accept;
    rtc_pkg::cell_ctl_t         ctl_tick;
    rtc_pkg::cell_ctl_t         ctl_time;
    rtc_pkg::cell_ctl_t         ctl_date;

    logic                       tick_carry;
    logic                       hold;
    logic                       sec_cin;
    logic                       sec_carry;
    logic                       min_carry;
    logic                       hour_carry;
    logic                       day_carry;
    logic                       mon_carry;
    logic                       leap;

    logic [rtc_pkg::SEC_W-1:0]  sec_val,  sec_nx,  sec_load;
    logic [rtc_pkg::MIN_W-1:0]  min_val,  min_nx,  min_load;
    logic [rtc_pkg::HOUR_W-1:0] hour_val, hour_nx, hour_load;
    logic [rtc_pkg::DAY_W-1:0]  day_val,  day_nx,  day_limit;
    logic [rtc_pkg::MON_W-1:0]  mon_val,  mon_nx;
    logic [rtc_pkg::YEAR_W-1:0] year_val, year_nx;
    logic [rtc_pkg::HOUR_W:0]   hour_sum;

    logic                       out_valid_reg;
    logic                       second_tick_reg;
    logic                       at_midnight_reg;
    logic [rtc_pkg::YEAR_W-1:0] year_reg;
    logic [rtc_pkg::MON_W-1:0]  month_reg;
    logic [rtc_pkg::DAY_W-1:0]  day_reg;
    logic [rtc_pkg::HOUR_W-1:0] hour_reg;
    logic [rtc_pkg::MIN_W-1:0]  minute_reg;
    logic [rtc_pkg::SEC_W-1:0]  second_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign ctl_tick = '{en: accept, load: (req_type == rtc_pkg::REQ_SYNC)};
    assign ctl_time = ctl_tick;
    assign ctl_date = '{en: accept, load: 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg  <= rtc_pkg::TPS_RESET;
            zone_reg <= rtc_pkg::ZONE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtc_pkg::CFG_TPS:  tps_reg  <= cfg_data;
                rtc_pkg::CFG_ZONE: zone_reg <= cfg_data[rtc_pkg::ZONE_W-1:0];
                default:           tps_reg  <= tps_reg;
            endcase
        end
    end

    // Sync values: hour gets the zone offset mod 24, minute and second clamp at 59.
    always_comb
    begin
        hour_sum = {1'b0, sync_hour} + {1'b0, zone_reg};
        if (hour_sum >= rtc_pkg::HOURS_TWO_DAY)
            hour_sum = hour_sum - rtc_pkg::HOURS_TWO_DAY;
        else if (hour_sum >= rtc_pkg::HOURS_PER_DAY)
            hour_sum = hour_sum - rtc_pkg::HOURS_PER_DAY;
        hour_load = hour_sum[rtc_pkg::HOUR_W-1:0];
        min_load  = (sync_minute > rtc_pkg::MIN_LAST) ? rtc_pkg::MIN_LAST : sync_minute;
        sec_load  = (sync_second > rtc_pkg::SEC_LAST) ? rtc_pkg::SEC_LAST : sync_second;
    end

    // The clock stops at the last second of the last supported year.
    assign hold = (year_val >= rtc_pkg::YEAR_MAX) && (mon_val == rtc_pkg::MON_LAST) &&
                  (day_val == rtc_pkg::DAY_LAST) && (hour_val == rtc_pkg::HOUR_LAST) &&
                  (min_val == rtc_pkg::MIN_LAST) && (sec_val == rtc_pkg::SEC_LAST);
    assign sec_cin   = tick_carry && !hold;
    assign day_limit = rtc_pkg::month_days(mon_val, leap);

    rtc_tick_cell u_tick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_tick),
        .divisor   (tps_reg),
        .carry_out (tick_carry)
    );

    rtc_cell #(.W(rtc_pkg::SEC_W)) u_sec (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_time),
        .rst_val    ('0),
        .base       ('0),
        .limit      (rtc_pkg::SEC_LAST),
        .load_val   (sec_load),
        .carry_in   (sec_cin),
        .value      (sec_val),
        .value_next (sec_nx),
        .carry_out  (sec_carry)
    );

    rtc_cell #(.W(rtc_pkg::MIN_W)) u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_time),
        .rst_val    ('0),
        .base       ('0),
        .limit      (rtc_pkg::MIN_LAST),
        .load_val   (min_load),
        .carry_in   (sec_carry),
        .value      (min_val),
        .value_next (min_nx),
        .carry_out  (min_carry)
    );

    rtc_cell #(.W(rtc_pkg::HOUR_W)) u_hour (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_time),
        .rst_val    ('0),
        .base       ('0),
        .limit      (rtc_pkg::HOUR_LAST),
        .load_val   (hour_load),
        .carry_in   (min_carry),
        .value      (hour_val),
        .value_next (hour_nx),
        .carry_out  (hour_carry)
    );

    rtc_cell #(.W(rtc_pkg::DAY_W)) u_day (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_date),
        .rst_val    (rtc_pkg::DAY_W'(1)),
        .base       (rtc_pkg::DAY_W'(1)),
        .limit      (day_limit),
        .load_val   (day_val),
        .carry_in   (hour_carry),
        .value      (day_val),
        .value_next (day_nx),
        .carry_out  (day_carry)
    );

    rtc_cell #(.W(rtc_pkg::MON_W)) u_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_date),
        .rst_val    (rtc_pkg::MON_W'(1)),
        .base       (rtc_pkg::MON_W'(1)),
        .limit      (rtc_pkg::MON_LAST),
        .load_val   (mon_val),
        .carry_in   (day_carry),
        .value      (mon_val),
        .value_next (mon_nx),
        .carry_out  (mon_carry)
    );

    rtc_year_cell u_year (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_date),
        .carry_in   (mon_carry),
        .value      (year_val),
        .value_next (year_nx),
        .leap       (leap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            second_tick_reg <= tick_carry;
            at_midnight_reg <= (hour_nx == '0) && (min_nx == '0) && (sec_nx == '0);
            year_reg        <= year_nx;
            month_reg       <= mon_nx;
            day_reg         <= day_nx;
            hour_reg        <= hour_nx;
            minute_reg      <= min_nx;
            second_reg      <= sec_nx;
        end
    end

    assign out_valid   = out_valid_reg;
    assign second_tick = second_tick_reg;
    assign at_midnight = at_midnight_reg;
    assign year        = year_reg;
    assign month       = month_reg;
    assign day         = day_reg;
    assign hour        = hour_reg;
    assign minute      = minute_reg;
    assign second      = second_reg;

endmodule

// ===== hdl/rtc_tick_cell.sv =====
// Sub-second tick counter cell that issues a carry when a second completes.
module rtc_tick_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtc_pkg::cell_ctl_t            ctl,
    input  logic [rtc_pkg::TICK_W-1:0]    divisor,
    output logic                          carry_out
);

    logic [rtc_pkg::TICK_W-1:0] count_reg;
    logic [rtc_pkg::TICK_W-1:0] count_next;
    logic [rtc_pkg::TICK_W:0]   inc;
    logic [rtc_pkg::TICK_W-1:0] div_eff;
    logic                       hit;

    always_comb
    begin
        inc     = {1'b0, count_reg} + {{rtc_pkg::TICK_W{1'b0}}, 1'b1};
        // A divisor of zero behaves as one.
        div_eff = (divisor == '0) ? {{(rtc_pkg::TICK_W-1){1'b0}}, 1'b1} : divisor;
        hit     = (inc >= {1'b0, div_eff});
        carry_out = ctl.en && !ctl.load && hit;
        count_next = count_reg;
        if (ctl.en)
        begin
            if (ctl.load || hit)
                count_next = '0;
            else
                count_next = inc[rtc_pkg::TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== hdl/rtc_cell.sv =====
// Generic wrapping counter cell for second, minute, hour, day and month.
module rtc_cell #(
    parameter int W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rtc_pkg::cell_ctl_t ctl,
    input  logic [W-1:0]       rst_val,
    input  logic [W-1:0]       base,
    input  logic [W-1:0]       limit,
    input  logic [W-1:0]       load_val,
    input  logic               carry_in,
    output logic [W-1:0]       value,
    output logic [W-1:0]       value_next,
    output logic               carry_out
);

    logic [W-1:0] value_reg;

    assign value     = value_reg;
    assign carry_out = carry_in && (value_reg == limit);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.en)
        begin
            if (ctl.load)
                value_next = load_val;
            else if (carry_in)
                value_next = (value_reg == limit) ? base : value_reg + W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= rst_val;
        else
            value_reg <= value_next;
    end

endmodule

// ===== hdl/rtc_year_cell.sv =====
// Year cell with running residues that give the leap-year flag.
module rtc_year_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtc_pkg::cell_ctl_t            ctl,
    input  logic                          carry_in,
    output logic [rtc_pkg::YEAR_W-1:0]    value,
    output logic [rtc_pkg::YEAR_W-1:0]    value_next,
    output logic                          leap
);

    logic [rtc_pkg::YEAR_W-1:0] year_reg;
    logic [1:0]                 mod4_reg;
    logic [6:0]                 mod100_reg;
    logic [8:0]                 mod400_reg;
    logic                       step;

    assign value = year_reg;
    assign step  = ctl.en && !ctl.load && carry_in;
    assign leap  = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign value_next = step ? year_reg + rtc_pkg::YEAR_W'(1) : year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= rtc_pkg::YEAR_RESET;
            mod4_reg   <= rtc_pkg::YR_MOD4_RESET;
            mod100_reg <= rtc_pkg::YR_MOD100_RESET;
            mod400_reg <= rtc_pkg::YR_MOD400_RESET;
        end
        else if (step)
        begin
            year_reg   <= value_next;
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == rtc_pkg::YR_MOD100_LAST) ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == rtc_pkg::YR_MOD400_LAST) ? 9'd0 : mod400_reg + 9'd1;
        end
    end

endmodule

// ===== hdl/rtc_checker.sv =====
// Port-level checks for the real-time clock, bound to the top level.
module rtc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          at_midnight,
    input logic [rtc_pkg::MON_W-1:0]     month,
    input logic [rtc_pkg::DAY_W-1:0]     day,
    input logic [rtc_pkg::HOUR_W-1:0]    hour,
    input logic [rtc_pkg::MIN_W-1:0]     minute,
    input logic [rtc_pkg::SEC_W-1:0]     second
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The input only stalls behind a held result.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending result");

    // Every accepted item shows a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    // The reported time of day stays legal, the month stays in 1..12 and the day is at least 1.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second <= 6'd59) && (minute <= 6'd59) && (hour <= 5'd23) &&
                      (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1))
        else $error("time or date out of range");

    // The midnight flag matches the reported time of day.
    a_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> at_midnight == ((hour == '0) && (minute == '0) && (second == '0)))
        else $error("midnight flag disagrees with time");

endmodule

bind rtc_calendar_counter rtc_checker u_rtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .at_midnight (at_midnight),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second)
);
